@@ rtl/core/tq_pkg.sv @@
// ---------------------------------------------------------------------------
// Timer queue package
// Shared constants, codes and record types of the timer queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tq_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int TIME_W = 63;
  localparam int IVAL_W = 32;
  localparam int TAG_W  = 16;
  localparam int SLOT_W = 4;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SUMMARY   = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IVAL_W-1:0] interval;
    logic [TAG_W-1:0]  tag;
  } slot_rec_t;

  // en: write this cycle; all: whole record, else expiry only
  typedef struct packed {
    logic en;
    logic all;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/tq_in_if.sv @@
// ---------------------------------------------------------------------------
// Timer queue command channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tq_in_if;
  logic                          valid;
  logic                          ready;
  logic [tq_pkg::CMD_W-1:0]      command;
  logic [tq_pkg::SLOT_W-1:0]     handle_slot;
  logic [tq_pkg::TAG_W-1:0]      handle_tag;
  logic [tq_pkg::TIME_W-1:0]     expiry_time;
  logic [tq_pkg::IVAL_W-1:0]     interval_us;
  logic [tq_pkg::TIME_W-1:0]     current_time;

  modport source (output valid, command, handle_slot, handle_tag, expiry_time,
                  interval_us, current_time, input ready);
  modport sink   (input valid, command, handle_slot, handle_tag, expiry_time,
                  interval_us, current_time, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tq_out_if.sv @@
// ---------------------------------------------------------------------------
// Timer queue result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tq_pkg::KIND_W-1:0]     kind;
  logic [tq_pkg::SLOT_W-1:0]     out_slot;
  logic [tq_pkg::TAG_W-1:0]      out_tag;
  logic                          head_moved;
  logic [tq_pkg::TIME_W-1:0]     next_expiry;
  logic                          next_valid;
  logic                          last;

  modport source (output valid, kind, out_slot, out_tag, head_moved,
                  next_expiry, next_valid, last, input ready);
  modport sink   (input valid, kind, out_slot, out_tag, head_moved,
                  next_expiry, next_valid, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tq_slot_mem.sv @@
// ---------------------------------------------------------------------------
// Timer slot memory
// Expiry, interval and tag per slot; one write and one registered read a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tq_slot_mem #(
  parameter int ENTRIES = tq_pkg::ENTRIES_DEF,
  localparam int IW = $clog2(ENTRIES)
) (
  input  wire                    clk,
  input  wire tq_pkg::mem_ctl_t  wr_ctl,
  input  wire [IW-1:0]           wr_addr,
  input  wire tq_pkg::slot_rec_t wr_data,
  input  wire [IW-1:0]           rd_addr,
  output tq_pkg::slot_rec_t      rd_data
);

  logic [tq_pkg::TIME_W-1:0] exp_mem [ENTRIES];
  logic [tq_pkg::IVAL_W-1:0] ival_mem [ENTRIES];
  logic [tq_pkg::TAG_W-1:0]  tag_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      exp_mem[wr_addr] <= wr_data.expiry;
      if (wr_ctl.all) begin
        ival_mem[wr_addr] <= wr_data.interval;
        tag_mem[wr_addr]  <= wr_data.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data.expiry   <= exp_mem[rd_addr];
    rd_data.interval <= ival_mem[rd_addr];
    rd_data.tag      <= tag_mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/expiry_ordered_timer_queue.sv @@
// ---------------------------------------------------------------------------
// Expiry-ordered timer queue
// Timer table with add, cancel and tick; repeating timers re-arm on expiry.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    command, handle, expiry, interval, time
//  out_chan  out  valid/ready    kind, slot, tag, earliest flag, next expiry
//
//  The slot memory is scanned one entry per cycle (registered read).
//  Add scans all slots for the earliest expiry, then fills the lowest free slot.
//  Cancel checks the handled slot, then scans; tick emits due timers earliest first.
//  Reset clears state, valid and due flags, tag and scan counters; no clearing pass.
//  A stalled result holds in the output register; the next result waits for it.
// ---------------------------------------------------------------------------
`default_nettype none

module expiry_ordered_timer_queue #(
  parameter int ENTRIES = tq_pkg::ENTRIES_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  tq_in_if.sink    in_chan,
  tq_out_if.source out_chan
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW:0] NCNT = (IW+1)'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CRD  = 6'b000100,
    S_CCMP = 6'b001000,
    S_EXP  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t st_r, st_nxt;

  // latched command
  logic [tq_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [tq_pkg::SLOT_W-1:0] hs_r, hs_nxt;
  logic [tq_pkg::TAG_W-1:0]  ht_r, ht_nxt;
  logic [tq_pkg::TIME_W-1:0] ex_r, ex_nxt;
  logic [tq_pkg::IVAL_W-1:0] iv_r, iv_nxt;
  logic [tq_pkg::TIME_W-1:0] now_r, now_nxt;

  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic [ENTRIES-1:0] due_r, due_nxt;
  logic [tq_pkg::TAG_W-1:0] tagc_r, tagc_nxt;

  // scan engine
  logic [IW:0]   sc_r, sc_nxt;
  logic          rv_r, rv_nxt;
  logic [IW-1:0] ra_r, ra_nxt;
  logic          md_tick_r, md_tick_nxt;
  logic          first_r, first_nxt;
  logic          bf_r, bf_nxt;
  logic [tq_pkg::TIME_W-1:0] be_r, be_nxt;
  logic [IW-1:0] bi_r, bi_nxt;
  logic [tq_pkg::TAG_W-1:0]  bt_r, bt_nxt;
  logic [tq_pkg::IVAL_W-1:0] bv_r, bv_nxt;
  logic          hit_r, hit_nxt;

  // output register
  logic ov_r, ov_nxt;
  logic [tq_pkg::KIND_W-1:0] ok_r, ok_nxt;
  logic [tq_pkg::SLOT_W-1:0] os_r, os_nxt;
  logic [tq_pkg::TAG_W-1:0]  ot_r, ot_nxt;
  logic oc_r, oc_nxt;
  logic [tq_pkg::TIME_W-1:0] oe_r, oe_nxt;
  logic on_r, on_nxt;
  logic ol_r, ol_nxt;

  tq_pkg::mem_ctl_t  mw_ctl;
  logic [IW-1:0]     mw_addr;
  tq_pkg::slot_rec_t mw_data;
  logic [IW-1:0]     mr_addr;
  tq_pkg::slot_rec_t mr_data;

  logic [IW-1:0] hs_idx;
  logic          hs_in_range;
  logic [IW-1:0] free_idx;
  logic          full;
  logic          ofree;
  logic          in_acc;
  logic          cand;
  logic          chg;
  logic [tq_pkg::TIME_W:0] rearm_sum;

  assign hs_idx      = IW'(hs_r);
  assign hs_in_range = 32'(hs_r) < 32'(ENTRIES);
  assign ofree       = !ov_r || out_chan.ready;
  assign in_acc      = in_chan.valid && in_chan.ready;
  assign full        = &vld_r;
  assign mr_addr     = (st_r == S_CRD) ? hs_idx : sc_r[IW-1:0];
  assign rearm_sum   = {1'b0, now_r} + {{(tq_pkg::TIME_W+1-tq_pkg::IVAL_W){1'b0}}, bv_r};
  assign chg         = !bf_r || (ex_r < be_r);

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) free_idx = IW'(i);
    end
  end

  tq_slot_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .wr_ctl  (mw_ctl),
    .wr_addr (mw_addr),
    .wr_data (mw_data),
    .rd_addr (mr_addr),
    .rd_data (mr_data)
  );

  always_comb begin
    st_nxt = st_r;
    cmd_nxt = cmd_r; hs_nxt = hs_r; ht_nxt = ht_r;
    ex_nxt = ex_r; iv_nxt = iv_r; now_nxt = now_r;
    vld_nxt = vld_r; due_nxt = due_r; tagc_nxt = tagc_r;
    sc_nxt = sc_r; rv_nxt = rv_r; ra_nxt = ra_r;
    md_tick_nxt = md_tick_r; first_nxt = first_r;
    bf_nxt = bf_r; be_nxt = be_r; bi_nxt = bi_r; bt_nxt = bt_r; bv_nxt = bv_r;
    hit_nxt = hit_r;
    ov_nxt = ov_r && !out_chan.ready;
    ok_nxt = ok_r; os_nxt = os_r; ot_nxt = ot_r; oc_nxt = oc_r;
    oe_nxt = oe_r; on_nxt = on_r; ol_nxt = ol_r;
    mw_ctl = '0;
    mw_addr = bi_r;
    mw_data.expiry = rearm_sum[tq_pkg::TIME_W] ? tq_pkg::TIME_MAX
                                               : rearm_sum[tq_pkg::TIME_W-1:0];
    mw_data.interval = iv_r;
    mw_data.tag = tagc_r;
    cand = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_chan.command;
          hs_nxt  = in_chan.handle_slot;
          ht_nxt  = in_chan.handle_tag;
          ex_nxt  = in_chan.expiry_time;
          iv_nxt  = in_chan.interval_us;
          now_nxt = in_chan.current_time;
          sc_nxt = '0; rv_nxt = 1'b0; bf_nxt = 1'b0;
          case (in_chan.command)
            tq_pkg::CMD_ADD: begin
              md_tick_nxt = 1'b0; first_nxt = 1'b0; st_nxt = S_SCAN;
            end
            tq_pkg::CMD_TICK: begin
              md_tick_nxt = 1'b1; first_nxt = 1'b1; st_nxt = S_SCAN;
            end
            tq_pkg::CMD_CANCEL: st_nxt = S_CRD;
            default: st_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (sc_r < NCNT) begin
          ra_nxt = sc_r[IW-1:0];
          sc_nxt = sc_r + 1'b1;
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          if (md_tick_r) begin
            cand = first_r ? (vld_r[ra_r] && (mr_data.expiry <= now_r)) : due_r[ra_r];
            if (first_r) due_nxt[ra_r] = cand;
          end else begin
            cand = vld_r[ra_r];
          end
          // strict compare in slot order keeps the lowest slot on ties
          if (cand && (!bf_r || (mr_data.expiry < be_r))) begin
            bf_nxt = 1'b1;
            be_nxt = mr_data.expiry;
            bi_nxt = ra_r;
            bt_nxt = mr_data.tag;
            bv_nxt = mr_data.interval;
          end
        end
        if ((sc_r == NCNT) && !rv_r) begin
          if (!md_tick_r) begin
            st_nxt = S_FIN;
          end else if (bf_r) begin
            st_nxt = S_EXP;
          end else begin
            md_tick_nxt = 1'b0;
            sc_nxt = '0; rv_nxt = 1'b0; bf_nxt = 1'b0;
          end
        end
      end

      S_CRD: st_nxt = S_CCMP;

      S_CCMP: begin
        hit_nxt = hs_in_range && vld_r[hs_idx] && (mr_data.tag == ht_r);
        if (hs_in_range && vld_r[hs_idx] && (mr_data.tag == ht_r)) begin
          vld_nxt[hs_idx] = 1'b0;
        end
        md_tick_nxt = 1'b0; first_nxt = 1'b0;
        sc_nxt = '0; rv_nxt = 1'b0; bf_nxt = 1'b0;
        st_nxt = S_SCAN;
      end

      S_EXP: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ok_nxt = tq_pkg::KIND_EXPIRED;
          os_nxt = tq_pkg::SLOT_W'(bi_r);
          ot_nxt = bt_r;
          oc_nxt = 1'b0; oe_nxt = '0; on_nxt = 1'b0; ol_nxt = 1'b0;
          due_nxt[bi_r] = 1'b0;
          if (bv_r != '0) begin
            mw_ctl.en = 1'b1;
            mw_addr = bi_r;
          end else begin
            vld_nxt[bi_r] = 1'b0;
          end
          first_nxt = 1'b0;
          sc_nxt = '0; rv_nxt = 1'b0; bf_nxt = 1'b0;
          st_nxt = S_SCAN;
        end
      end

      S_FIN: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          oc_nxt = 1'b0;
          os_nxt = '0;
          ot_nxt = '0;
          oe_nxt = bf_r ? be_r : '0;
          on_nxt = bf_r;
          case (cmd_r)
            tq_pkg::CMD_ADD: begin
              if (full) begin
                ok_nxt = tq_pkg::KIND_FULL;
              end else begin
                ok_nxt = tq_pkg::KIND_ADDED;
                os_nxt = tq_pkg::SLOT_W'(free_idx);
                ot_nxt = tagc_r;
                oc_nxt = chg;
                oe_nxt = chg ? ex_r : be_r;
                on_nxt = 1'b1;
                mw_ctl.en = 1'b1;
                mw_ctl.all = 1'b1;
                mw_addr = free_idx;
                mw_data.expiry = ex_r;
                vld_nxt[free_idx] = 1'b1;
                tagc_nxt = tagc_r + 1'b1;
              end
            end
            tq_pkg::CMD_CANCEL: begin
              ok_nxt = hit_r ? tq_pkg::KIND_CANCELLED : tq_pkg::KIND_NOT_FOUND;
              os_nxt = hs_r;
              ot_nxt = ht_r;
            end
            default: ok_nxt = tq_pkg::KIND_SUMMARY;
          endcase
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      vld_r  <= '0;
      due_r  <= '0;
      tagc_r <= '0;
      sc_r   <= '0;
      rv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      vld_r  <= vld_nxt;
      due_r  <= due_nxt;
      tagc_r <= tagc_nxt;
      sc_r   <= sc_nxt;
      rv_r   <= rv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; hs_r <= hs_nxt; ht_r <= ht_nxt;
    ex_r <= ex_nxt; iv_r <= iv_nxt; now_r <= now_nxt;
    ra_r <= ra_nxt; md_tick_r <= md_tick_nxt; first_r <= first_nxt;
    bf_r <= bf_nxt; be_r <= be_nxt; bi_r <= bi_nxt; bt_r <= bt_nxt; bv_r <= bv_nxt;
    hit_r <= hit_nxt;
    ok_r <= ok_nxt; os_r <= os_nxt; ot_r <= ot_nxt; oc_r <= oc_nxt;
    oe_r <= oe_nxt; on_r <= on_nxt; ol_r <= ol_nxt;
  end

  assign in_chan.ready        = (st_r == S_IDLE);
  assign out_chan.valid       = ov_r;
  assign out_chan.kind        = ok_r;
  assign out_chan.out_slot    = os_r;
  assign out_chan.out_tag     = ot_r;
  assign out_chan.head_moved  = oc_r;
  assign out_chan.next_expiry = oe_r;
  assign out_chan.next_valid  = on_r;
  assign out_chan.last        = ol_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state register not one-hot");

  a_add_to_free: assert property (@(posedge clk) disable iff (!rst_n)
    (mw_ctl.en && mw_ctl.all) |-> !vld_r[mw_addr])
    else $error("add overwrote a pending slot");

  a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (ok_r == tq_pkg::KIND_EXPIRED)) |-> !ol_r)
    else $error("expired result marked last");

  a_rearm_was_due: assert property (@(posedge clk) disable iff (!rst_n)
    (mw_ctl.en && !mw_ctl.all) |=> !due_r[$past(mw_addr)])
    else $error("re-armed slot still marked due");

endmodule

`default_nettype wire
